// ===== sv/vrfp_pkg.sv =====
// shared types and constants of the variable record frame parser
`default_nettype none

package vrfp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;
  typedef logic [3:0] nib_t;

  // result status codes
  localparam status_t STATUS_RECORD   = 2'd0;
  localparam status_t STATUS_EMPTY    = 2'd1;
  localparam status_t STATUS_CSUM_ERR = 2'd2;
  localparam status_t STATUS_TOO_MANY = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'd1;

  // sync reset values
  localparam byte_t FIRST_SYNC_RST  = 8'hFF;
  localparam byte_t SECOND_SYNC_RST = 8'hEE;

  // byte counter width, enough for fifteen records plus header and checksum
  localparam int CNT_W = 6;

endpackage

`default_nettype wire

// ===== sv/vrfp_in_if.sv =====
// received byte channel
`default_nettype none

interface vrfp_in_if;
  import vrfp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/vrfp_out_if.sv =====
// parsed result channel
`default_nettype none

interface vrfp_out_if;
  import vrfp_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  nib_t    record_count;
  nib_t    record_index;
  byte_t   class_code;
  byte_t   distance;
  byte_t   direction;
  byte_t   obj_width;
  logic    last;

  modport source (output valid, output status, output record_count, output record_index,
                  output class_code, output distance, output direction, output obj_width,
                  output last, input ready);
  modport sink   (input valid, input status, input record_count, input record_index,
                  input class_code, input distance, input direction, input obj_width,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== sv/variable_record_frame_parser_top.sv =====
// Frame parser: one byte per request; header checks, checksum, then records replayed from store.
// Header and record bytes are taken whenever in_ready is high; in_ready drops while results are produced.
// After a good checksum byte each record is read (4 store reads through one read port) and waits
// for its output handshake; error and empty-frame results appear the cycle after their byte.
// Reset (synchronous, rst_n low) clears the byte count and running sum and restores sync bytes;
// the store is not cleared, only entries written for the current frame are ever read.
`default_nettype none

module variable_record_frame_parser_top #(
  parameter int MAX_RECORDS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [vrfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire vrfp_pkg::byte_t                   cfg_data,
  vrfp_in_if.sink                                in_chan,
  vrfp_out_if.source                             out_chan
);
  import vrfp_pkg::*;

  localparam int STORE_DEPTH = 4 * MAX_RECORDS;
  localparam int AW          = $clog2(STORE_DEPTH);

  localparam logic [1:0] S_RECV = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  byte_t          sum_r, sum_nxt;
  byte_t          h0_r, h0_nxt, h1_r, h1_nxt, h2_r, h2_nxt;
  nib_t           k_r, k_nxt;
  logic [2:0]     ph_r, ph_nxt;
  byte_t          sync0_r, sync1_r;

  status_t        status_r, status_nxt;
  nib_t           count_r, count_nxt;
  nib_t           index_r, index_nxt;
  byte_t          class_r, class_nxt;
  byte_t          dist_r, dist_nxt;
  byte_t          dir_r, dir_nxt;
  byte_t          width_r, width_nxt;
  logic           last_r, last_nxt;

  logic           in_acc;
  byte_t          b;
  byte_t          sum_add;
  logic [6:0]     chk_pos;
  logic           st_we;
  logic [AW-1:0]  st_waddr;
  logic [AW-1:0]  st_raddr;
  byte_t          st_rdata;

  assign in_chan.ready = (state_r == S_RECV);
  assign in_acc        = in_chan.valid && (state_r == S_RECV);
  assign b             = in_chan.rx_byte;
  assign sum_add       = sum_r + b;
  assign chk_pos       = {1'b0, h2_r[3:0], 2'b00} + 7'd3;
  assign st_waddr      = AW'(cnt_r - CNT_W'(3));
  assign st_raddr      = AW'({k_r, ph_r[1:0]});

  vrfp_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (b),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  // sequencer and next values
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    h0_nxt     = h0_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    k_nxt      = k_r;
    ph_nxt     = ph_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    index_nxt  = index_r;
    class_nxt  = class_r;
    dist_nxt   = dist_r;
    dir_nxt    = dir_r;
    width_nxt  = width_r;
    last_nxt   = last_r;
    st_we      = 1'b0;

    case (state_r)
      S_RECV: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(3)) begin
            // header bytes
            cnt_nxt = cnt_r + CNT_W'(1);
            sum_nxt = sum_add;
            if (cnt_r == CNT_W'(0)) begin
              h0_nxt = b;
            end else if (cnt_r == CNT_W'(1)) begin
              h1_nxt = b;
            end else if (h0_r != sync0_r || h1_r != sync1_r) begin
              // slide window by one byte
              sum_nxt = sum_add - h0_r;
              h0_nxt  = h1_r;
              h1_nxt  = b;
              cnt_nxt = CNT_W'(2);
            end else if (b > 8'(MAX_RECORDS)) begin
              // count too large
              status_nxt = STATUS_TOO_MANY;
              count_nxt  = (b > 8'd15) ? 4'hF : b[3:0];
              index_nxt  = 4'd0;
              class_nxt  = 8'd0;
              dist_nxt   = 8'd0;
              dir_nxt    = 8'd0;
              width_nxt  = 8'd0;
              last_nxt   = 1'b1;
              cnt_nxt    = '0;
              sum_nxt    = 8'd0;
              state_nxt  = S_EMIT;
            end else begin
              h2_nxt = b;
            end
          end else if ({1'b0, cnt_r} < chk_pos) begin
            // record byte
            st_we   = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            sum_nxt = sum_add;
          end else begin
            // checksum byte
            cnt_nxt    = '0;
            sum_nxt    = 8'd0;
            count_nxt  = h2_r[3:0];
            index_nxt  = 4'd0;
            class_nxt  = 8'd0;
            dist_nxt   = 8'd0;
            dir_nxt    = 8'd0;
            width_nxt  = 8'd0;
            last_nxt   = 1'b1;
            if (sum_r != b) begin
              status_nxt = STATUS_CSUM_ERR;
              state_nxt  = S_EMIT;
            end else if (h2_r == 8'd0) begin
              status_nxt = STATUS_EMPTY;
              state_nxt  = S_EMIT;
            end else begin
              k_nxt     = 4'd0;
              ph_nxt    = 3'd0;
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        // one store read per cycle, data lands in the following cycle
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd1: class_nxt = st_rdata;
          3'd2: dist_nxt  = st_rdata;
          3'd3: dir_nxt   = st_rdata;
          3'd4: begin
            width_nxt  = st_rdata;
            status_nxt = STATUS_RECORD;
            count_nxt  = h2_r[3:0];
            index_nxt  = k_r;
            last_nxt   = ((k_r + 4'd1) == h2_r[3:0]);
            ph_nxt     = 3'd0;
            state_nxt  = S_EMIT;
          end
          default: ;
        endcase
      end
      S_EMIT: begin
        if (out_chan.ready) begin
          if (last_r) begin
            state_nxt = S_RECV;
          end else begin
            k_nxt     = k_r + 4'd1;
            ph_nxt    = 3'd0;
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
      cnt_r   <= '0;
      sum_r   <= 8'd0;
      k_r     <= 4'd0;
      ph_r    <= 3'd0;
      sync0_r <= FIRST_SYNC_RST;
      sync1_r <= SECOND_SYNC_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      k_r     <= k_nxt;
      ph_r    <= ph_nxt;
      if (cfg_we && cfg_index == CFG_FIRST_SYNC) begin
        sync0_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_SECOND_SYNC) begin
        sync1_r <= cfg_data;
      end
    end
  end

  // header and result payload
  always_ff @(posedge clk) begin
    h0_r     <= h0_nxt;
    h1_r     <= h1_nxt;
    h2_r     <= h2_nxt;
    status_r <= status_nxt;
    count_r  <= count_nxt;
    index_r  <= index_nxt;
    class_r  <= class_nxt;
    dist_r   <= dist_nxt;
    dir_r    <= dir_nxt;
    width_r  <= width_nxt;
    last_r   <= last_nxt;
  end

  // result channel
  assign out_chan.valid        = (state_r == S_EMIT);
  assign out_chan.status       = status_r;
  assign out_chan.record_count = count_r;
  assign out_chan.record_index = index_r;
  assign out_chan.class_code   = class_r;
  assign out_chan.distance     = dist_r;
  assign out_chan.direction    = dir_r;
  assign out_chan.obj_width    = width_r;
  assign out_chan.last         = last_r;

endmodule

`default_nettype wire

// ===== sv/vrfp_store.sv =====
// record byte store, one write port and one registered read port
`default_nettype none

module vrfp_store #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire vrfp_pkg::byte_t wr_data,
  input  wire logic [AW-1:0]  rd_addr,
  output vrfp_pkg::byte_t     rd_data
);
  import vrfp_pkg::*;

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
